// ----- rtl/core/spi_rfs_pkg.sv -----
// Shared types and constants for the SPI reply frame scanner.
// Used by spi_rfs_scan, spi_rfs_outq and spi_reply_frame_scanner.
package spi_rfs_pkg;

    localparam int unsigned LENGTH_BITS = 16;

    localparam logic [7:0] BYTE_NULL_LO = 8'h00;
    localparam logic [7:0] BYTE_NULL_HI = 8'hFF;
    localparam logic [7:0] BYTE_REPLY   = 8'h02;
    localparam logic [7:0] BYTE_NACK    = 8'h04;

    localparam logic [7:0] MAX_LEN_RESET = 8'd20;

    typedef enum logic [0:0] {
        CFG_MAX_REPLY_LEN  = 1'b0,
        CFG_REPLY_EXPECTED = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NACK   = 3'd1,
        ST_NOMARK = 3'd2,
        ST_NORESP = 3'd3,
        ST_TRUNC  = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic [6:0] {
        PH_SEARCH   = 7'b0000001,
        PH_SKIP     = 7'b0000010,
        PH_LEN_HI   = 7'b0000100,
        PH_LEN_LO   = 7'b0001000,
        PH_PAYLOAD  = 7'b0010000,
        PH_COMPLETE = 7'b0100000,
        PH_NACKED   = 7'b1000000
    } t_phase;

    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload;
        t_status     status;
        logic [15:0] length;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0] max_reply_len;
        logic       reply_expected;
    } t_cfg;

endpackage

// ----- rtl/core/spi_rfs_scan.sv -----
// Per-byte frame scan: phase state and result generation for one byte.
// Depends on spi_rfs_pkg.
module spi_rfs_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    input  logic                  i_wend,
    input  spi_rfs_pkg::t_cfg     i_cfg,
    output logic [1:0]            o_nres,
    output spi_rfs_pkg::t_result  o_res0,
    output spi_rfs_pkg::t_result  o_res1
);

    spi_rfs_pkg::t_phase r_phase, n_phase;
    logic                r_null,  n_null;
    spi_rfs_pkg::t_len   r_len,   n_len;
    spi_rfs_pkg::t_len   r_cnt,   n_cnt;

    logic                                  pay;
    logic [spi_rfs_pkg::LENGTH_BITS+7:0]   len_cat;
    spi_rfs_pkg::t_len                     cnt_inc;
    spi_rfs_pkg::t_status                  st;
    logic [15:0]                           st_len;
    spi_rfs_pkg::t_result                  pay_res, stat_res;

    assign len_cat = {r_len, i_byte};
    assign cnt_inc = r_cnt + spi_rfs_pkg::LENGTH_BITS'(1);

    always_comb begin
        n_phase = r_phase;
        n_null  = r_null;
        n_len   = r_len;
        n_cnt   = r_cnt;
        pay     = 1'b0;
        if (i_cfg.reply_expected) begin
            case (r_phase)
                spi_rfs_pkg::PH_SEARCH: begin
                    if (i_byte != spi_rfs_pkg::BYTE_NULL_LO &&
                        i_byte != spi_rfs_pkg::BYTE_NULL_HI) begin
                        n_null = 1'b0;
                    end
                    if (i_byte == spi_rfs_pkg::BYTE_REPLY) begin
                        n_phase = spi_rfs_pkg::PH_SKIP;
                    end else if (i_byte == spi_rfs_pkg::BYTE_NACK) begin
                        n_phase = spi_rfs_pkg::PH_NACKED;
                    end
                end
                spi_rfs_pkg::PH_SKIP: begin
                    n_phase = spi_rfs_pkg::PH_LEN_HI;
                end
                spi_rfs_pkg::PH_LEN_HI: begin
                    n_len   = spi_rfs_pkg::LENGTH_BITS'(i_byte);
                    n_phase = spi_rfs_pkg::PH_LEN_LO;
                end
                spi_rfs_pkg::PH_LEN_LO: begin
                    n_len   = len_cat[spi_rfs_pkg::LENGTH_BITS-1:0];
                    n_cnt   = '0;
                    n_phase = (len_cat[spi_rfs_pkg::LENGTH_BITS-1:0] == '0)
                              ? spi_rfs_pkg::PH_COMPLETE : spi_rfs_pkg::PH_PAYLOAD;
                end
                spi_rfs_pkg::PH_PAYLOAD: begin
                    pay   = ({8'd0, r_cnt} <
                             (spi_rfs_pkg::LENGTH_BITS + 8)'(i_cfg.max_reply_len));
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_phase = spi_rfs_pkg::PH_COMPLETE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        st     = spi_rfs_pkg::ST_TRUNC;
        st_len = '0;
        if (!i_cfg.reply_expected) begin
            st = spi_rfs_pkg::ST_OK;
        end else begin
            case (n_phase)
                spi_rfs_pkg::PH_COMPLETE: begin
                    st     = spi_rfs_pkg::ST_OK;
                    st_len = 16'(n_len);
                end
                spi_rfs_pkg::PH_NACKED: st = spi_rfs_pkg::ST_NACK;
                spi_rfs_pkg::PH_SEARCH: begin
                    st = n_null ? spi_rfs_pkg::ST_NORESP : spi_rfs_pkg::ST_NOMARK;
                end
                spi_rfs_pkg::PH_PAYLOAD: st_len = 16'(n_len);
                default: st = spi_rfs_pkg::ST_TRUNC;
            endcase
        end
    end

    always_comb begin
        pay_res.kind    = spi_rfs_pkg::KIND_PAYLOAD;
        pay_res.payload = i_byte;
        pay_res.status  = spi_rfs_pkg::ST_OK;
        pay_res.length  = 16'(n_len);
        pay_res.last    = !i_wend;

        stat_res.kind    = spi_rfs_pkg::KIND_STATUS;
        stat_res.payload = 8'd0;
        stat_res.status  = st;
        stat_res.length  = st_len;
        stat_res.last    = 1'b1;

        o_res0 = pay ? pay_res : stat_res;
        o_res1 = stat_res;
        o_nres = {1'b0, pay} + {1'b0, i_wend};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spi_rfs_pkg::PH_SEARCH;
            r_null  <= 1'b1;
            r_len   <= '0;
            r_cnt   <= '0;
        end else if (i_advance) begin
            if (i_wend) begin
                r_phase <= spi_rfs_pkg::PH_SEARCH;
                r_null  <= 1'b1;
                r_len   <= '0;
                r_cnt   <= '0;
            end else begin
                r_phase <= n_phase;
                r_null  <= n_null;
                r_len   <= n_len;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule

// ----- rtl/core/spi_rfs_outq.sv -----
// Two-entry result queue; takes up to two results per cycle, gives one.
// Depends on spi_rfs_pkg.
module spi_rfs_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_n,
    input  spi_rfs_pkg::t_result  i_res0,
    input  spi_rfs_pkg::t_result  i_res1,
    input  logic                  i_pop_ready,
    output logic                  o_valid,
    output spi_rfs_pkg::t_result  o_head,
    output logic [1:0]            o_free
);

    spi_rfs_pkg::t_result r_q0, r_q1, n_q0, n_q1;
    logic [1:0]           r_cnt, n_cnt, cnt_after;
    logic                 pop;
    spi_rfs_pkg::t_result a0;

    assign o_valid   = (r_cnt != 2'd0);
    assign o_head    = r_q0;
    assign pop       = o_valid && i_pop_ready;
    assign cnt_after = r_cnt - {1'b0, pop};
    assign a0        = pop ? r_q1 : r_q0;
    assign o_free    = 2'd2 - cnt_after;

    always_comb begin
        n_q0  = a0;
        n_q1  = r_q1;
        n_cnt = cnt_after + i_push_n;
        case (cnt_after)
            2'd0: begin
                n_q0 = i_res0;
                n_q1 = i_res1;
            end
            2'd1: n_q1 = i_res0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

// ----- rtl/core/spi_reply_frame_scanner.sv -----
// Takes one received byte per cycle from an input register while the output queue has
// room for its results, scans it against the window state and returns results from a
// two-entry output queue: reply payload bytes up to max_reply_len, and one status
// transfer on the tlast byte. A tlast byte that also yields a payload byte produces two
// output transfers, so the output side sets the pace for it. The input path is one
// register plus the queue. Configuration writes are always ready and are registered.
// Top level; depends on spi_rfs_pkg, spi_rfs_scan and spi_rfs_outq.
module spi_reply_frame_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // window_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status_code,
                                        // [26:11] reply_length, [31:27] zero
    output logic        m_axis_tuser,   // item_kind
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_wend;
    spi_rfs_pkg::t_cfg    r_cfg;
    logic                 advance;
    logic [1:0]           nres, free;
    spi_rfs_pkg::t_result res0, res1, head;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (nres <= free);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_reply_len  <= spi_rfs_pkg::MAX_LEN_RESET;
            r_cfg.reply_expected <= 1'b1;
        end else if (i_cfg_valid) begin
            case (spi_rfs_pkg::t_cfg_index'(i_cfg_index))
                spi_rfs_pkg::CFG_MAX_REPLY_LEN:  r_cfg.max_reply_len  <= i_cfg_data;
                spi_rfs_pkg::CFG_REPLY_EXPECTED: r_cfg.reply_expected <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_wend <= s_axis_tlast;
        end
    end

    spi_rfs_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_wend    (r_in_wend),
        .i_cfg     (r_cfg),
        .o_nres    (nres),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    spi_rfs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (advance ? nres : 2'd0),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_pop_ready (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_head      (head),
        .o_free      (free)
    );

    assign m_axis_tdata = {5'd0, head.length, head.status, head.payload};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
        else $error("status transfer without tlast or with payload");

    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[10:8] == spi_rfs_pkg::ST_OK))
        else $error("payload transfer with nonzero status");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
